// File: rtl/twq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twq_pkg;

  // Command codes carried in the command field of an input word.
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NOP    = 2'd3
  } twq_cmd_t;

  localparam int unsigned CmdBits   = 2;
  localparam int unsigned PidBits   = 8;
  localparam int unsigned CountBits = 16;
  localparam int unsigned HeldBits  = 5;

  // Per-cycle operation strobes broadcast to every cell of the chain.
  typedef struct packed {
    logic append;
    logic remove;
    logic tick;
  } twq_ctl_t;

endpackage

`default_nettype wire

// File: rtl/twq_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface twq_cmd_if import twq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CmdBits-1:0]   command;
  logic [PidBits-1:0]   process_id;
  logic [CountBits-1:0] wait_time;

  modport source (output valid, command, process_id, wait_time, input ready);
  modport sink (input valid, command, process_id, wait_time, output ready);
endinterface

`default_nettype wire

// File: rtl/twq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface twq_rsp_if import twq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PidBits-1:0]  released_id;
  logic                released_valid;
  logic [HeldBits-1:0] entries_held;
  logic                overflow;

  modport source (output valid, released_id, released_valid, entries_held, overflow,
                  input ready);
  modport sink (input valid, released_id, released_valid, entries_held, overflow,
                output ready);
endinterface

`default_nettype wire

// File: rtl/twq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One queue slot. Position IDX holds the entry that is IDX places from the
// oldest one. A cell hands its undecremented contents to its older neighbor.
module twq_cell import twq_pkg::*; #(
  parameter int unsigned IDX     = 0,
  parameter int unsigned ID_BITS = 8,
  parameter int unsigned OCC_W   = 5
) (
  input  wire logic                 clk,
  input  wire twq_ctl_t             ctl,
  input  wire logic [OCC_W-1:0]     occupancy,
  input  wire logic [ID_BITS-1:0]   load_id,
  input  wire logic [CountBits-1:0] load_count,
  input  wire logic [ID_BITS-1:0]   nbr_id,
  input  wire logic [CountBits-1:0] nbr_count,
  input  wire logic                 hit_in,
  input  wire logic [ID_BITS-1:0]   rel_in,
  output logic [ID_BITS-1:0]        id,
  output logic [CountBits-1:0]      count,
  output logic                      hit_out,
  output logic [ID_BITS-1:0]        rel_out
);

  logic                 held;
  logic [CountBits-1:0] dec;
  logic                 hit_here;
  logic                 shift;
  logic                 load;

  always_comb begin
    held     = occupancy > OCC_W'(IDX);
    dec      = count - CountBits'(1);
    hit_here = ctl.tick & held & (dec == '0);
    hit_out  = hit_in | hit_here;
    // Remove, or a tick at or after the woken cell, loads the younger neighbor's entry.
    shift    = ctl.remove | (ctl.tick & hit_out);
    load     = ctl.append & (occupancy == OCC_W'(IDX));
    rel_out  = (hit_here & ~hit_in) ? id : rel_in;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      id    <= load_id;
      count <= load_count;
    end else if (shift) begin
      id    <= nbr_id;
      count <= nbr_count;
    end else if (ctl.tick) begin
      count <= dec;
    end
  end

endmodule

`default_nettype wire

// File: rtl/timed_wait_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Timed wait queue: an ordered queue of process ids, each with a 16-bit
// timeout count, held in a row of slot cells with the oldest entry in cell 0.
// Channel req (sink) takes one word per command: append (process_id and
// wait_time), remove oldest, or timer tick. Command code 3 changes nothing.
// Channel rsp (source) returns exactly one word per request word: the
// released id and its valid flag, the entry count after the command, and an
// overflow flag for an append that found the queue full.
// Results are registered: a request word accepted at one edge shows its result
// word on rsp after that edge. One request word is taken every cycle while
// the response register is empty or being emptied in the same cycle, so the
// sustained rate is one word per cycle.
// A tick decrements every held count up to the first one that reaches zero;
// that entry is released and younger entries keep their counts. The first-hit
// search is a combinational priority chain running through all the cells.
// When rsp stalls, the result word stays in its register and req.ready drops
// until it is taken; nothing is lost or repeated.
// Reset (rst, synchronous) empties the queue and the response register; the
// slot contents are not cleared, since only held slots are ever read.
module timed_wait_queue_unit import twq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input wire logic clk,
  input wire logic rst,
  twq_cmd_if.sink   req,
  twq_rsp_if.source rsp
);

  localparam int unsigned OccW = $clog2(QUEUE_DEPTH + 1);

  logic [OccW-1:0]      occupancy;
  logic [OccW-1:0]      occupancy_next;
  logic                 accept;
  twq_ctl_t             ctl;
  logic                 full;
  logic [ID_BITS-1:0]   load_id;

  // Cell outputs and the chains that run from the oldest cell to the youngest.
  logic [ID_BITS-1:0]   cell_id    [QUEUE_DEPTH];
  logic [CountBits-1:0] cell_count [QUEUE_DEPTH];
  logic                 hit_chain  [QUEUE_DEPTH+1];
  logic [ID_BITS-1:0]   rel_chain  [QUEUE_DEPTH+1];

  logic                 rel_valid_next;
  logic [ID_BITS-1:0]   rel_id_next;
  logic                 ovf_next;

  // The response register is the only buffer: a new word may enter whenever
  // it is empty or its word leaves at this edge.
  assign req.ready = ~rsp.valid | rsp.ready;
  assign accept    = req.valid & req.ready;

  always_comb begin
    ctl.append = accept & (req.command == CMD_APPEND);
    ctl.remove = accept & (req.command == CMD_REMOVE);
    ctl.tick   = accept & (req.command == CMD_TICK);
    full       = occupancy == OccW'(QUEUE_DEPTH);
    load_id    = ID_BITS'(req.process_id);
  end

  assign hit_chain[0] = 1'b0;
  assign rel_chain[0] = '0;

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic [ID_BITS-1:0]   nbr_id;
    logic [CountBits-1:0] nbr_count;

    if (k + 1 < QUEUE_DEPTH) begin : g_mid
      assign nbr_id    = cell_id[k+1];
      assign nbr_count = cell_count[k+1];
    end else begin : g_last
      assign nbr_id    = '0;
      assign nbr_count = '0;
    end

    twq_cell #(
      .IDX     (k),
      .ID_BITS (ID_BITS),
      .OCC_W   (OccW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupancy  (occupancy),
      .load_id    (load_id),
      .load_count (req.wait_time),
      .nbr_id     (nbr_id),
      .nbr_count  (nbr_count),
      .hit_in     (hit_chain[k]),
      .rel_in     (rel_chain[k]),
      .id         (cell_id[k]),
      .count      (cell_count[k]),
      .hit_out    (hit_chain[k+1]),
      .rel_out    (rel_chain[k+1])
    );
  end

  // Result of the word being accepted, and the count it leaves behind.
  always_comb begin
    occupancy_next = occupancy;
    rel_valid_next = 1'b0;
    rel_id_next    = '0;
    ovf_next       = 1'b0;
    if (ctl.append) begin
      if (full) begin
        ovf_next = 1'b1;
      end else begin
        occupancy_next = occupancy + OccW'(1);
      end
    end else if (ctl.remove) begin
      if (occupancy != '0) begin
        rel_valid_next = 1'b1;
        rel_id_next    = cell_id[0];
        occupancy_next = occupancy - OccW'(1);
      end
    end else if (ctl.tick) begin
      if (hit_chain[QUEUE_DEPTH]) begin
        rel_valid_next = 1'b1;
        rel_id_next    = rel_chain[QUEUE_DEPTH];
        occupancy_next = occupancy - OccW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      rsp.valid <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    if (accept) begin
      rsp.released_id    <= PidBits'(rel_id_next);
      rsp.released_valid <= rel_valid_next;
      rsp.entries_held   <= HeldBits'(occupancy_next);
      rsp.overflow       <= ovf_next;
    end
  end

  // The queue never holds more entries than it has cells.
  a_occ_bound : assert property (@(posedge clk) disable iff (rst)
    occupancy <= OccW'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  // An append to a full queue leaves the entry count alone.
  a_full_append : assert property (@(posedge clk) disable iff (rst)
    (ctl.append && full) |=> (occupancy == OccW'(QUEUE_DEPTH)))
    else $error("dropped append changed occupancy");

  // A remove from a non-empty queue frees exactly one slot.
  a_remove_count : assert property (@(posedge clk) disable iff (rst)
    (ctl.remove && occupancy != '0) |=> (occupancy == $past(occupancy) - OccW'(1)))
    else $error("remove did not free one slot");

  // A word never both releases an entry and reports a dropped append.
  a_rel_ovf : assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.released_valid && rsp.overflow))
    else $error("release and overflow in one word");

endmodule

`default_nettype wire

// File: tb/twq_checker.sv
`timescale 1ns / 1ps

module twq_checker import twq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  twq_cmd_if   req,
  twq_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [PidBits-1:0]  id;
    logic                released;
    logic [HeldBits-1:0] held;
    logic                overflow;
  } release_word_t;

  // Shadow of the queue, oldest entry at index 0.
  logic [PidBits-1:0]   held_ids    [DEPTH];
  logic [CountBits-1:0] held_counts [DEPTH];
  int unsigned          held_total;

  release_word_t release_q [$];

  function automatic void drop_entry(int unsigned pos);
    int unsigned k;
    for (k = pos; k + 1 < held_total; k++) begin
      held_ids[k]    = held_ids[k + 1];
      held_counts[k] = held_counts[k + 1];
    end
    held_total--;
  endfunction

  function automatic release_word_t apply_word(twq_cmd_t op, logic [PidBits-1:0] pid,
                                               logic [CountBits-1:0] wait_count);
    release_word_t w;
    int unsigned   k;
    bit            woken;
    w     = '0;
    woken = 1'b0;
    case (op)
      CMD_APPEND: begin
        if (held_total >= DEPTH) begin
          w.overflow = 1'b1;
        end else begin
          held_ids[held_total]    = pid;
          held_counts[held_total] = wait_count;
          held_total++;
        end
      end
      CMD_REMOVE: begin
        if (held_total > 0) begin
          w.id       = held_ids[0];
          w.released = 1'b1;
          drop_entry(0);
        end
      end
      CMD_TICK: begin
        // The walk stops at the first count that reaches zero.
        for (k = 0; k < held_total && !woken; k++) begin
          held_counts[k] = held_counts[k] - 1'b1;
          if (held_counts[k] == '0) begin
            w.id       = held_ids[k];
            w.released = 1'b1;
            drop_entry(k);
            woken = 1'b1;
          end
        end
      end
      default: ;
    endcase
    w.held = HeldBits'(held_total);
    return w;
  endfunction

  always @(posedge clk) begin
    release_word_t want;
    int            errs;
    errs = 0;
    if (rst) begin
      held_total = 0;
      release_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      // A result word never belongs to a request taken at the same edge.
      if (rsp.valid && rsp.ready) begin
        if (release_q.size() == 0) begin
          $error("unexpected result word: released_id %0d", rsp.released_id);
          errs++;
        end else begin
          want = release_q.pop_front();
          if (rsp.released_id !== want.id) begin
            $error("released_id: expected %0d, actual %0d", want.id, rsp.released_id);
            errs++;
          end
          if (rsp.released_valid !== want.released) begin
            $error("released_valid: expected %0d, actual %0d", want.released,
                   rsp.released_valid);
            errs++;
          end
          if (rsp.entries_held !== want.held) begin
            $error("entries_held: expected %0d, actual %0d", want.held, rsp.entries_held);
            errs++;
          end
          if (rsp.overflow !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, rsp.overflow);
            errs++;
          end
        end
      end
      if (req.valid && req.ready) begin
        release_q.push_back(apply_word(twq_cmd_t'(req.command), req.process_id,
                                       req.wait_time));
      end
      fail_count <= fail_count + errs;
      pending    <= release_q.size();
    end
  end

endmodule

// File: tb/timed_wait_queue_unit_tb.sv
`timescale 1ns / 1ps

module timed_wait_queue_unit_tb;
  import twq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned ID_WIDTH     = 8;
  localparam int          RANDOM_ITEMS = 1850;
  // Longest stretch without any accepted word before the run is called hung.
  localparam int          QUIET_LIMIT  = 1000;
  // Length of the deliberate result-side stall that backs up the request side.
  localparam int          LONG_HOLD    = 80;

  logic clk;
  logic rst;
  logic steady;      // when high, neither side inserts random idle cycles
  int   fail_count;
  int   pending;
  int   quiet_cycles;

  twq_cmd_if req_ch ();
  twq_rsp_if rsp_ch ();

  timed_wait_queue_unit #(
    .QUEUE_DEPTH (DEPTH),
    .ID_BITS     (ID_WIDTH)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  twq_checker #(
    .DEPTH (DEPTH)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offers one request word and returns after the edge that accepts it.
  // Outside the steady stretch the request side goes quiet roughly 18 times
  // in a hundred before offering the word.
  task automatic issue_word(input twq_cmd_t op, input logic [PidBits-1:0] pid,
                            input logic [CountBits-1:0] wait_count);
    if (!steady && $urandom_range(99) < 18) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= op;
    req_ch.process_id <= pid;
    req_ch.wait_time  <= wait_count;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stops offering words until every expected result word has come back.
  // The extra edge lets the checker's count include the last accepted word.
  task automatic settle_queue();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  // Mostly short waits so that ticks wake entries often, with zero, the top
  // value and full-width random counts mixed in so every bit toggles.
  function automatic logic [CountBits-1:0] pick_wait_time();
    int r;
    r = $urandom_range(99);
    if (r < 60) return CountBits'($urandom_range(6, 1));
    if (r < 70) return '0;
    if (r < 80) return CountBits'($urandom);
    if (r < 90) return CountBits'($urandom_range(40, 7));
    return '1 - CountBits'($urandom_range(3));
  endfunction

  initial begin : stimulus
    int          k;
    int          counted;
    int          mode;
    int          r;
    int          append_lim;
    int          remove_lim;
    twq_cmd_t    op;
    req_ch.valid      <= 1'b0;
    req_ch.command    <= CMD_NOP;
    req_ch.process_id <= '0;
    req_ch.wait_time  <= '0;
    steady            <= 1'b0;
    rst               <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty queue: remove and tick release nothing, command 3 is ignored.
    issue_word(CMD_REMOVE, '0, '0);
    issue_word(CMD_TICK, '0, '0);
    issue_word(CMD_NOP, '1, '1);

    // Extremes of id and wait time, then two entries that both wait one tick.
    // The first tick wakes the third entry and leaves the fourth
    // untouched; the second tick wakes the fourth. The zero wait wraps.
    issue_word(CMD_APPEND, '1, '1);
    issue_word(CMD_APPEND, '0, '0);
    issue_word(CMD_APPEND, 8'hA5, 16'd1);
    issue_word(CMD_APPEND, 8'h5A, 16'd1);
    issue_word(CMD_TICK, '0, '0);
    issue_word(CMD_TICK, '0, '0);

    // Fill the queue to the brim, then one append that must be dropped.
    for (k = 0; k < DEPTH - 2; k++) begin
      issue_word(CMD_APPEND, PidBits'(k * 17 + 3), CountBits'(k + 2));
    end
    issue_word(CMD_APPEND, 8'h3C, 16'd9);
    issue_word(CMD_REMOVE, '0, '0);

    // The request side stays quiet until every result word is back.
    settle_queue();

    // Random part in segments of 64 words, each with its own bias: balanced,
    // fill-heavy (reaches overflow), or tick-heavy (drains and wakes).
    counted    = 0;
    mode       = 0;
    append_lim = 40;
    remove_lim = 60;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 64 == 0) begin
        mode = $urandom_range(2);
      end
      case (mode)
        0: begin
          append_lim = 40;
          remove_lim = 60;
        end
        1: begin
          append_lim = 70;
          remove_lim = 80;
        end
        default: begin
          append_lim = 25;
          remove_lim = 40;
        end
      endcase
      // A stretch in the middle runs with no idle cycles on either side.
      steady <= (counted >= 700 && counted < 1000);
      r = $urandom_range(99);
      if (r < append_lim) op = CMD_APPEND;
      else if (r < remove_lim) op = CMD_REMOVE;
      else if (r < 97) op = CMD_TICK;
      else op = CMD_NOP;
      issue_word(op, PidBits'($urandom), pick_wait_time());
      // Ignored words still return a result but do not count as stimulus.
      if (op != CMD_NOP) begin
        counted++;
      end
    end

    settle_queue();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: random backpressure, plus two long holds counted here so
  // the response register stays full and the request side has to stall.
  initial begin : receiver
    int cycles;
    int hold_left;
    cycles    = 0;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycles++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (cycles == 800 || cycles == 1800) begin
        hold_left = LONG_HOLD - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= 18);
      end
    end
  end

  // Watchdog: any accepted word on either channel restarts the count.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: filelist.f
rtl/twq_pkg.sv
rtl/twq_cmd_if.sv
rtl/twq_rsp_if.sv
rtl/twq_cell.sv
rtl/timed_wait_queue_unit.sv
tb/twq_checker.sv
tb/timed_wait_queue_unit_tb.sv
